// File: hdl/multichannel_frame_fifo_assert.svh
// Assertion helpers for the frame FIFO checkers.
// Both expect signals named clock and reset in the calling scope.
`ifndef MULTICHANNEL_FRAME_FIFO_ASSERT_SVH
`define MULTICHANNEL_FRAME_FIFO_ASSERT_SVH

// Same-cycle implication.
`define MFF_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define MFF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/mff_pkg.sv
package mff_pkg;

   localparam int LVL_W     = 11;
   localparam int RET_W     = 7;
   localparam int SMP_W     = 32;
   localparam int CSR_W     = 11;
   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 4;

   localparam logic [1:0] FUNC_HEADER = 2'd0;
   localparam logic [1:0] FUNC_DATA   = 2'd1;
   localparam logic [1:0] FUNC_POP    = 2'd2;

   localparam logic [1:0] KIND_ACK   = 2'd0;
   localparam logic [1:0] KIND_FRAME = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;

   localparam logic CSR_CAPACITY = 1'b0;
   localparam logic CSR_CHANNELS = 1'b1;

   localparam logic [10:0] CAPACITY_RESET = 11'd1024;
   localparam logic [2:0]  CHANNELS_RESET = 3'd4;

   typedef enum logic [1:0] {
      OP_HEADER,
      OP_DATA,
      OP_POP
   } op_type;

   typedef enum logic {
      ST_IDLE,
      ST_POP
   } eng_state_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [10:0] frame_count;
      logic [7:0]  first_channel;
      logic [8:0]  available_channels;
      logic [3:0]  present_mask;
      logic [31:0] sample_0;
      logic [31:0] sample_1;
      logic [31:0] sample_2;
      logic [31:0] sample_3;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic        accepted;
      logic [10:0] level;
      logic [10:0] high_water;
      logic [31:0] out_sample_0;
      logic [31:0] out_sample_1;
      logic [31:0] out_sample_2;
      logic [31:0] out_sample_3;
      logic        last;
      logic [6:0]  frames_returned;
   } rsp_type;

   // Classified command passed from the front end to the engine.
   typedef struct packed {
      op_type           op;
      logic [10:0]      frame_count;
      logic [6:0]       pop_max;
      logic [7:0]       first_channel;
      logic [8:0]       available_channels;
      logic [3:0]       present_mask;
      logic [3:0][31:0] samples;
   } cmd_type;

endpackage

// File: hdl/mff_front.sv
module mff_front #(
   parameter int MAX_POP = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  mff_pkg::req_type req_data,
   output logic             cmd_valid,
   output mff_pkg::cmd_type cmd_head,
   input  logic             cmd_take
);

   mff_pkg::cmd_type cmd_q_ff [mff_pkg::CMD_DEPTH];
   logic [1:0]       wr_ptr_ff, wr_ptr_in;
   logic [1:0]       rd_ptr_ff, rd_ptr_in;
   logic [2:0]       count_ff, count_in;

   mff_pkg::cmd_type cmd_new;
   logic             keep;
   logic             q_wr;
   logic             q_rd;

   always_comb begin
      cmd_new                    = '0;
      cmd_new.op                 = mff_pkg::OP_HEADER;
      cmd_new.frame_count        = req_data.frame_count;
      cmd_new.first_channel      = req_data.first_channel;
      cmd_new.available_channels = req_data.available_channels;
      cmd_new.present_mask       = req_data.present_mask;
      cmd_new.samples[0]         = req_data.sample_0;
      cmd_new.samples[1]         = req_data.sample_1;
      cmd_new.samples[2]         = req_data.sample_2;
      cmd_new.samples[3]         = req_data.sample_3;
      cmd_new.pop_max            = (req_data.frame_count > 11'(MAX_POP)) ?
                                   7'(MAX_POP) : req_data.frame_count[6:0];
      keep = 1'b1;
      unique case (req_data.func)
         mff_pkg::FUNC_HEADER: cmd_new.op = mff_pkg::OP_HEADER;
         mff_pkg::FUNC_DATA:   cmd_new.op = mff_pkg::OP_DATA;
         mff_pkg::FUNC_POP:    cmd_new.op = mff_pkg::OP_POP;
         default:              keep = 1'b0;   // drop unknown function codes
      endcase
   end

   assign req_full  = (count_ff == 3'(mff_pkg::CMD_DEPTH));
   assign q_wr      = req_push && !req_full && keep;
   assign cmd_valid = (count_ff != 3'd0);
   assign q_rd      = cmd_take && cmd_valid;
   assign cmd_head  = cmd_q_ff[rd_ptr_ff];

   assign wr_ptr_in = q_wr ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
   assign rd_ptr_in = q_rd ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
   assign count_in  = count_ff + 3'(q_wr) - 3'(q_rd);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_wr) begin
         cmd_q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// File: hdl/mff_rsp_queue.sv
module mff_rsp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  mff_pkg::rsp_type wr_data,
   input  logic             rd_en,
   output mff_pkg::rsp_type rd_data,
   output logic             empty,
   output logic [2:0]       count
);

   mff_pkg::rsp_type rsp_q_ff [mff_pkg::RSP_DEPTH];
   logic [1:0]       wr_ptr_ff, wr_ptr_in;
   logic [1:0]       rd_ptr_ff, rd_ptr_in;
   logic [2:0]       count_ff, count_in;
   logic             q_rd;

   assign empty   = (count_ff == 3'd0);
   assign count   = count_ff;
   assign rd_data = rsp_q_ff[rd_ptr_ff];
   assign q_rd    = rd_en && !empty;

   // The engine only writes when it holds a free slot.
   assign wr_ptr_in = wr_en ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
   assign rd_ptr_in = q_rd ? rd_ptr_ff + 2'd1 : rd_ptr_ff;
   assign count_in  = count_ff + 3'(wr_en) - 3'(q_rd);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         rsp_q_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: hdl/mff_back.sv
module mff_back #(
   parameter int DEPTH = 1024,
   parameter int LANES = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [10:0]      csr_wdata,
   input  logic             cmd_valid,
   input  mff_pkg::cmd_type cmd_head,
   output logic             cmd_take,
   input  logic [2:0]       rsp_count,
   output logic             rsp_wr,
   output mff_pkg::rsp_type rsp_wdata
);

   localparam int IDX_W = $clog2(DEPTH);

   // Frame store: one row of LANES words per frame.
   logic [LANES-1:0][31:0] sample_mem [DEPTH];
   logic [LANES-1:0][31:0] rd_row_ff;
   logic [LANES-1:0][31:0] wr_row;
   logic                   mem_we;
   logic                   mem_re;

   mff_pkg::eng_state_type state_ff, state_in;

   logic [10:0]      cap_cfg_ff, cap_cfg_in;
   logic [2:0]       chans_cfg_ff, chans_cfg_in;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0] commit_idx_ff, commit_idx_in;
   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [10:0]      level_ff, level_in;
   logic [10:0]      peak_ff, peak_in;
   logic [10:0]      pending_ff, pending_in;
   logic [10:0]      block_ff, block_in;
   logic [7:0]       map_first_ff, map_first_in;
   logic [8:0]       map_avail_ff, map_avail_in;
   logic [3:0]       map_present_ff, map_present_in;
   logic [6:0]       pop_left_ff, pop_left_in;
   logic [6:0]       pop_total_ff, pop_total_in;

   logic             stg_valid_ff, stg_valid_in;
   mff_pkg::rsp_type stg_rsp_ff, stg_rsp_in;
   logic [3:0]       stg_lanes_ff, stg_lanes_in;

   logic [10:0]      eff_cap;
   logic [2:0]       eff_chans;
   logic             room;
   logic [6:0]       pop_n;
   logic             hdr_ok;
   logic [IDX_W-1:0] wr_next;
   logic [IDX_W-1:0] rd_next;
   logic [11:0]      level_sum;
   logic [10:0]      level_commit;
   logic [3:0]       rd_lanes;
   logic [LANES-1:0] wr_lane_ok;
   logic [3:0][31:0] out_word;

   always_comb begin
      if (cap_cfg_ff == 11'd0) begin
         eff_cap = 11'd1;
      end else if (32'(cap_cfg_ff) > 32'(DEPTH)) begin
         eff_cap = 11'(DEPTH);
      end else begin
         eff_cap = cap_cfg_ff;
      end
      if (chans_cfg_ff == 3'd0) begin
         eff_chans = 3'd1;
      end else if (32'(chans_cfg_ff) > 32'(LANES)) begin
         eff_chans = 3'(LANES);
      end else begin
         eff_chans = chans_cfg_ff;
      end
   end

   assign room    = (32'(rsp_count) + 32'(stg_valid_ff)) < 32'(mff_pkg::RSP_DEPTH);
   assign pop_n   = ({4'd0, cmd_head.pop_max} > level_ff) ? level_ff[6:0] : cmd_head.pop_max;
   assign hdr_ok  = (cmd_head.frame_count <= (eff_cap - level_ff));
   assign wr_next = (32'(wr_idx_ff) + 32'd1 >= 32'(eff_cap)) ? '0 : wr_idx_ff + 1'b1;
   assign rd_next = (32'(rd_idx_ff) + 32'd1 >= 32'(eff_cap)) ? '0 : rd_idx_ff + 1'b1;

   assign level_sum    = 12'(level_ff) + 12'(block_ff);
   assign level_commit = (level_sum > 12'(eff_cap)) ? eff_cap : level_sum[10:0];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         wr_lane_ok[l] = (3'(l) < eff_chans) && map_present_ff[l] &&
                         (10'(map_first_ff) + 10'(l) < 10'(map_avail_ff));
         wr_row[l]     = wr_lane_ok[l] ? cmd_head.samples[l] : '0;
      end
      for (int l = 0; l < 4; l++) begin
         rd_lanes[l] = (3'(l) < eff_chans);
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mff_pkg::ST_IDLE: begin
            if (cmd_valid && cmd_head.op == mff_pkg::OP_POP && room && pop_n != 7'd0) begin
               state_in = mff_pkg::ST_POP;
            end
         end
         mff_pkg::ST_POP: begin
            if (room && pop_left_ff == 7'd1) begin
               state_in = mff_pkg::ST_IDLE;
            end
         end
         default: state_in = mff_pkg::ST_IDLE;
      endcase
   end

   // Engine outputs and datapath updates
   always_comb begin
      cmd_take       = 1'b0;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      cap_cfg_in     = cap_cfg_ff;
      chans_cfg_in   = chans_cfg_ff;
      wr_idx_in      = wr_idx_ff;
      commit_idx_in  = commit_idx_ff;
      rd_idx_in      = rd_idx_ff;
      level_in       = level_ff;
      peak_in        = peak_ff;
      pending_in     = pending_ff;
      block_in       = block_ff;
      map_first_in   = map_first_ff;
      map_avail_in   = map_avail_ff;
      map_present_in = map_present_ff;
      pop_left_in    = pop_left_ff;
      pop_total_in   = pop_total_ff;
      stg_valid_in   = 1'b0;
      stg_rsp_in     = '0;
      stg_lanes_in   = '0;

      unique case (state_ff)
         mff_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd_head.op)
                  mff_pkg::OP_HEADER: begin
                     if (room) begin
                        cmd_take = 1'b1;
                        // abandon an unfinished block
                        if (pending_ff != 11'd0) begin
                           wr_idx_in  = commit_idx_ff;
                           pending_in = '0;
                        end
                        if (hdr_ok) begin
                           map_first_in   = cmd_head.first_channel;
                           map_avail_in   = cmd_head.available_channels;
                           map_present_in = cmd_head.present_mask;
                           pending_in     = cmd_head.frame_count;
                           block_in       = cmd_head.frame_count;
                        end
                        stg_valid_in           = 1'b1;
                        stg_rsp_in.result_kind = mff_pkg::KIND_ACK;
                        stg_rsp_in.accepted    = hdr_ok;
                        stg_rsp_in.level       = level_ff;
                        stg_rsp_in.high_water  = peak_ff;
                        stg_rsp_in.last        = 1'b1;
                     end
                  end
                  mff_pkg::OP_DATA: begin
                     cmd_take = 1'b1;
                     if (pending_ff != 11'd0) begin
                        mem_we     = 1'b1;
                        wr_idx_in  = wr_next;
                        pending_in = pending_ff - 11'd1;
                        if (pending_ff == 11'd1) begin
                           commit_idx_in = wr_next;
                           level_in      = level_commit;
                           if (level_commit > peak_ff) begin
                              peak_in = level_commit;
                           end
                        end
                     end
                  end
                  mff_pkg::OP_POP: begin
                     if (room) begin
                        cmd_take = 1'b1;
                        if (pop_n == 7'd0) begin
                           stg_valid_in           = 1'b1;
                           stg_rsp_in.result_kind = mff_pkg::KIND_EMPTY;
                           stg_rsp_in.level       = level_ff;
                           stg_rsp_in.high_water  = peak_ff;
                           stg_rsp_in.last        = 1'b1;
                        end else begin
                           level_in     = level_ff - 11'(pop_n);
                           pop_left_in  = pop_n;
                           pop_total_in = pop_n;
                        end
                     end
                  end
                  default: cmd_take = 1'b1;
               endcase
            end
         end
         mff_pkg::ST_POP: begin
            if (room) begin
               mem_re                     = 1'b1;
               rd_idx_in                  = rd_next;
               pop_left_in                = pop_left_ff - 7'd1;
               stg_valid_in               = 1'b1;
               stg_lanes_in               = rd_lanes;
               stg_rsp_in.result_kind     = mff_pkg::KIND_FRAME;
               stg_rsp_in.level           = level_ff;
               stg_rsp_in.high_water      = peak_ff;
               stg_rsp_in.last            = (pop_left_ff == 7'd1);
               stg_rsp_in.frames_returned = pop_total_ff;
            end
         end
         default: ;
      endcase

      if (csr_wr_en) begin
         unique case (csr_index)
            mff_pkg::CSR_CAPACITY: begin
               cap_cfg_in    = csr_wdata;
               wr_idx_in     = '0;
               commit_idx_in = '0;
               rd_idx_in     = '0;
               level_in      = '0;
               pending_in    = '0;
               block_in      = '0;
            end
            mff_pkg::CSR_CHANNELS: chans_cfg_in = csr_wdata[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= mff_pkg::ST_IDLE;
         cap_cfg_ff     <= mff_pkg::CAPACITY_RESET;
         chans_cfg_ff   <= mff_pkg::CHANNELS_RESET;
         wr_idx_ff      <= '0;
         commit_idx_ff  <= '0;
         rd_idx_ff      <= '0;
         level_ff       <= '0;
         peak_ff        <= '0;
         pending_ff     <= '0;
         block_ff       <= '0;
         map_first_ff   <= '0;
         map_avail_ff   <= '0;
         map_present_ff <= '0;
         pop_left_ff    <= '0;
         pop_total_ff   <= '0;
         stg_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cap_cfg_ff     <= cap_cfg_in;
         chans_cfg_ff   <= chans_cfg_in;
         wr_idx_ff      <= wr_idx_in;
         commit_idx_ff  <= commit_idx_in;
         rd_idx_ff      <= rd_idx_in;
         level_ff       <= level_in;
         peak_ff        <= peak_in;
         pending_ff     <= pending_in;
         block_ff       <= block_in;
         map_first_ff   <= map_first_in;
         map_avail_ff   <= map_avail_in;
         map_present_ff <= map_present_in;
         pop_left_ff    <= pop_left_in;
         pop_total_ff   <= pop_total_in;
         stg_valid_ff   <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stg_rsp_ff   <= stg_rsp_in;
      stg_lanes_ff <= stg_lanes_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         sample_mem[wr_idx_ff] <= wr_row;
      end
      if (mem_re) begin
         rd_row_ff <= sample_mem[rd_idx_ff];
      end
   end

   // Read data is registered alongside the staged result, so the two line up in the cycle after the issue.
   genvar g;
   generate
      for (g = 0; g < 4; g++) begin : g_out
         if (g < LANES) begin : g_lane
            assign out_word[g] = stg_lanes_ff[g] ? rd_row_ff[g] : '0;
         end else begin : g_none
            assign out_word[g] = '0;
         end
      end
   endgenerate

   assign rsp_wr = stg_valid_ff;

   always_comb begin
      rsp_wdata              = stg_rsp_ff;
      rsp_wdata.out_sample_0 = out_word[0];
      rsp_wdata.out_sample_1 = out_word[1];
      rsp_wdata.out_sample_2 = out_word[2];
      rsp_wdata.out_sample_3 = out_word[3];
   end

endmodule

// File: hdl/multichannel_frame_fifo.sv
// Multichannel audio frame FIFO.
// Input queue: assert req_push with req_data while req_full is low. A push
// header reserves frame_count frames or is rejected; the data items that
// follow store one frame each, and the block becomes readable once its last
// frame is stored. A pop request returns up to min(frame_count, MAX_POP)
// frames, one result each; a pop that finds nothing returns one result.
// Result queue: while rsp_empty is low, rsp_data holds the oldest result;
// rsp_pop transfers it.
// Configuration: csr_wr_en writes csr_wdata to register csr_index
// (0 capacity in frames, 1 channels per frame); the user must write only
// while the block is idle, which the block itself does not enforce.
// A capacity write empties the ring. Flow: each result passes the engine's
// staging register before the result queue. A pop of n frames makes one
// frame-store read per frame and takes no new item until its last frame is
// staged; its frames follow one per cycle while the result queue has room.
// Reset empties the ring, clears the high-water mark and sets capacity 1024
// and four channels; the frame store is not cleared. When the receiver
// stalls, the result queue fills, the engine holds at its next header or
// pop, and the 4-entry input queue takes items until it raises req_full.
module multichannel_frame_fifo #(
   parameter int DEPTH   = 1024,
   parameter int LANES   = 4,
   parameter int MAX_POP = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  mff_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output mff_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [10:0]      csr_wdata
);

   logic             cmd_valid;
   mff_pkg::cmd_type cmd_head;
   logic             cmd_take;
   logic [2:0]       rsp_count;
   logic             rsp_wr;
   mff_pkg::rsp_type rsp_wdata;

   mff_front #(
      .MAX_POP (MAX_POP)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_head  (cmd_head),
      .cmd_take  (cmd_take)
   );

   mff_back #(
      .DEPTH (DEPTH),
      .LANES (LANES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_valid (cmd_valid),
      .cmd_head  (cmd_head),
      .cmd_take  (cmd_take),
      .rsp_count (rsp_count),
      .rsp_wr    (rsp_wr),
      .rsp_wdata (rsp_wdata)
   );

   mff_rsp_queue u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_wr),
      .wr_data (rsp_wdata),
      .rd_en   (rsp_pop),
      .rd_data (rsp_data),
      .empty   (rsp_empty),
      .count   (rsp_count)
   );

endmodule

// File: hdl/mff_checker.sv
`include "multichannel_frame_fifo_assert.svh"

module mff_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_empty,
   input logic             rsp_pop,
   input mff_pkg::rsp_type rsp_data
);

   // hold a stalled result
   `MFF_ASSERT_NEXT(a_rsp_hold, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_data), "stalled result changed")

   `MFF_ASSERT_IMPLY(a_ack_shape, !rsp_empty && rsp_data.result_kind == mff_pkg::KIND_ACK, rsp_data.last && rsp_data.frames_returned == 7'd0 && rsp_data.out_sample_0 == 32'd0, "push acknowledge malformed")

   `MFF_ASSERT_IMPLY(a_frame_shape, !rsp_empty && rsp_data.result_kind == mff_pkg::KIND_FRAME, rsp_data.frames_returned != 7'd0 && !rsp_data.accepted, "popped frame malformed")

   `MFF_ASSERT_IMPLY(a_level_peak, !rsp_empty, rsp_data.level <= rsp_data.high_water, "level above high-water mark")

   // high-water mark never drops from one transfer to the next result
   `MFF_ASSERT_NEXT(a_peak_rise, !rsp_empty && rsp_pop, rsp_empty || rsp_data.high_water >= $past(rsp_data.high_water), "high-water mark decreased")

endmodule

bind multichannel_frame_fifo mff_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int DEPTH         = 1024;
   localparam int LANES         = 4;
   localparam int MAX_POP       = 64;
   localparam int CLK_PERIOD    = 4;
   localparam int RESET_CYCLES  = 11;
   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 3000;
   localparam int PHASE_ITEMS   = 6;

   // Not decoded by the block: must be dropped without a result.
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_push = 1'b0;
   logic             req_full;
   mff_pkg::req_type req_data = '0;
   logic             rsp_empty;
   logic             rsp_pop = 1'b0;
   mff_pkg::rsp_type rsp_data;
   logic             csr_wr_en = 1'b0;
   logic             csr_index = 1'b0;
   logic [10:0]      csr_wdata = '0;

   // Shadow copy of the ring.
   logic [31:0] shadow_store [DEPTH][LANES];
   logic [9:0]  shadow_wr = '0;
   logic [9:0]  shadow_commit = '0;
   logic [9:0]  shadow_rd = '0;
   logic [10:0] shadow_level = '0;
   logic [10:0] shadow_peak = '0;
   logic [10:0] shadow_pending = '0;
   logic [10:0] shadow_block = '0;
   logic [7:0]  shadow_first = '0;
   logic [8:0]  shadow_avail = '0;
   logic [3:0]  shadow_mask = '0;
   logic [10:0] shadow_cap = mff_pkg::CAPACITY_RESET;
   logic [2:0]  shadow_chans = mff_pkg::CHANNELS_RESET;

   mff_pkg::rsp_type ring_replies [$];
   mff_pkg::rsp_type oldest_reply;
   int      mismatch_count = 0;
   int      items_sent = 0;
   int      idle_cycles = 0;
   int      tx_burst = 0;
   int      rx_burst = 0;
   bit      sender_no_gap = 1'b0;
   bit      hold_request = 1'b0;
   bit      hold_active = 1'b0;

   multichannel_frame_fifo #(
      .DEPTH   (DEPTH),
      .LANES   (LANES),
      .MAX_POP (MAX_POP)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic logic [10:0] ring_capacity();
      if (shadow_cap == 0) return 11'd1;
      if (shadow_cap > DEPTH) return 11'(DEPTH);
      return shadow_cap;
   endfunction

   function automatic logic [2:0] ring_channels();
      if (shadow_chans == 0) return 3'd1;
      if (shadow_chans > LANES) return 3'(LANES);
      return shadow_chans;
   endfunction

   function automatic void ring_clear();
      shadow_wr = '0;
      shadow_commit = '0;
      shadow_rd = '0;
      shadow_level = '0;
      shadow_pending = '0;
      shadow_block = '0;
   endfunction

   // Advance the shadow ring by one transferred item and queue its replies.
   task automatic ring_apply(mff_pkg::req_type item);
      mff_pkg::rsp_type reply;
      logic [10:0] cap;
      logic [2:0]  chans;
      int unsigned count;
      int unsigned sum;
      logic [31:0] frames [MAX_POP][LANES];
      cap = ring_capacity();
      chans = ring_channels();
      reply = '0;
      case (item.func)
         mff_pkg::FUNC_HEADER: begin
            // a new header abandons any block still loading
            if (shadow_pending != 0) begin
               shadow_wr = shadow_commit;
               shadow_pending = '0;
            end
            if (item.frame_count <= cap - shadow_level) begin
               reply.accepted = 1'b1;
               shadow_first = item.first_channel;
               shadow_avail = item.available_channels;
               shadow_mask = item.present_mask;
               shadow_pending = item.frame_count;
               shadow_block = item.frame_count;
            end
            reply.result_kind = mff_pkg::KIND_ACK;
            reply.level = shadow_level;
            reply.high_water = shadow_peak;
            reply.last = 1'b1;
            ring_replies.push_back(reply);
         end
         mff_pkg::FUNC_DATA: begin
            if (shadow_pending != 0) begin
               for (int lane = 0; lane < LANES; lane++) begin
                  if (lane < chans && shadow_mask[lane] &&
                      int'(shadow_first) + lane < int'(shadow_avail))
                     shadow_store[shadow_wr][lane] = item[32 * (LANES - 1 - lane) +: 32];
                  else
                     shadow_store[shadow_wr][lane] = '0;
               end
               shadow_wr = (shadow_wr + 1 >= cap) ? 10'd0 : shadow_wr + 10'd1;
               shadow_pending = shadow_pending - 11'd1;
               if (shadow_pending == 0) begin
                  shadow_commit = shadow_wr;
                  sum = shadow_level + shadow_block;
                  shadow_level = (sum > cap) ? cap : 11'(sum);
                  if (shadow_level > shadow_peak) shadow_peak = shadow_level;
               end
            end
         end
         mff_pkg::FUNC_POP: begin
            count = item.frame_count;
            if (count > MAX_POP) count = MAX_POP;
            if (count > shadow_level) count = shadow_level;
            if (count == 0) begin
               reply.result_kind = mff_pkg::KIND_EMPTY;
               reply.level = shadow_level;
               reply.high_water = shadow_peak;
               reply.last = 1'b1;
               ring_replies.push_back(reply);
            end else begin
               for (int f = 0; f < count; f++) begin
                  for (int lane = 0; lane < LANES; lane++)
                     frames[f][lane] = (lane < chans) ? shadow_store[shadow_rd][lane] : '0;
                  shadow_rd = (shadow_rd + 1 >= cap) ? 10'd0 : shadow_rd + 10'd1;
               end
               shadow_level = shadow_level - 11'(count);
               for (int f = 0; f < count; f++) begin
                  reply = '0;
                  reply.result_kind = mff_pkg::KIND_FRAME;
                  reply.level = shadow_level;
                  reply.high_water = shadow_peak;
                  reply.out_sample_0 = frames[f][0];
                  reply.out_sample_1 = frames[f][1];
                  reply.out_sample_2 = frames[f][2];
                  reply.out_sample_3 = frames[f][3];
                  reply.last = (f + 1 == count);
                  reply.frames_returned = 7'(count);
                  ring_replies.push_back(reply);
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      if (!reset && req_push && !req_full) ring_apply(req_data);
   end

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         if (ring_replies.size() == 0) begin
            mismatch_count++;
            $display("%0t: result expected none actual %h", $time, rsp_data);
         end else begin
            oldest_reply = ring_replies.pop_front();
            check_field("result_kind", 32'(oldest_reply.result_kind),
                        32'(rsp_data.result_kind));
            check_field("accepted", 32'(oldest_reply.accepted), 32'(rsp_data.accepted));
            check_field("level", 32'(oldest_reply.level), 32'(rsp_data.level));
            check_field("high_water", 32'(oldest_reply.high_water),
                        32'(rsp_data.high_water));
            check_field("out_sample_0", oldest_reply.out_sample_0, rsp_data.out_sample_0);
            check_field("out_sample_1", oldest_reply.out_sample_1, rsp_data.out_sample_1);
            check_field("out_sample_2", oldest_reply.out_sample_2, rsp_data.out_sample_2);
            check_field("out_sample_3", oldest_reply.out_sample_3, rsp_data.out_sample_3);
            check_field("last", 32'(oldest_reply.last), 32'(rsp_data.last));
            check_field("frames_returned", 32'(oldest_reply.frames_returned),
                        32'(rsp_data.frames_returned));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL multichannel_frame_fifo");
         $finish;
      end
   end

   // Mostly random gaps, with the odd run of back-to-back transfers.
   function automatic int draw_gap(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         burst = $urandom_range(10, 30);
         return 0;
      end
      return $urandom_range(0, 9);
   endfunction

   initial begin
      int stall;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_pop <= 1'b0;
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_active = 1'b0;
            hold_request = 1'b0;
         end else begin
            stall = draw_gap(rx_burst);
            if (stall != 0) begin
               rsp_pop <= 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty && !hold_request);
      end
   end

   function automatic mff_pkg::req_type random_item(logic [1:0] func, logic [10:0] count);
      mff_pkg::req_type item;
      item.func = func;
      item.frame_count = count;
      item.first_channel = $urandom_range(0, 1) ? 8'($urandom_range(0, 255)) :
                                                  8'($urandom_range(0, 3));
      item.available_channels = 9'($urandom_range(0, 256));
      item.present_mask = 4'($urandom_range(0, 15));
      item.sample_0 = $urandom;
      item.sample_1 = $urandom;
      item.sample_2 = $urandom;
      item.sample_3 = $urandom;
      return item;
   endfunction

   function automatic mff_pkg::req_type header_item(logic [10:0] count, logic [7:0] first,
                                                    logic [8:0] avail, logic [3:0] mask);
      mff_pkg::req_type item;
      item = random_item(mff_pkg::FUNC_HEADER, count);
      item.first_channel = first;
      item.available_channels = avail;
      item.present_mask = mask;
      return item;
   endfunction

   // Present one item and hold it until the block takes it.
   task automatic send_item(mff_pkg::req_type item);
      int gap;
      gap = sender_no_gap ? 0 : draw_gap(tx_burst);
      @(negedge clock);
      if (gap != 0) begin
         req_push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_full);
      if (item.func != FUNC_UNUSED) items_sent++;
   endtask

   task automatic send_op(logic [1:0] func, logic [10:0] count);
      send_item(random_item(func, count));
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_push <= 1'b0;
      while (ring_replies.size() != 0) @(posedge clock);
      // data items still queued in the block leave no result behind
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic index, logic [10:0] value);
      wait_idle();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (index == mff_pkg::CSR_CAPACITY) begin
         shadow_cap = value;
         ring_clear();
      end else begin
         shadow_chans = value[2:0];
      end
   endtask

   task automatic test_directed_ops();
      mff_pkg::req_type item;
      send_op(mff_pkg::FUNC_POP, 11'd0);
      send_op(mff_pkg::FUNC_DATA, 11'd0);
      send_op(FUNC_UNUSED, 11'd0);
      send_op(mff_pkg::FUNC_HEADER, 11'd2047);
      send_op(mff_pkg::FUNC_HEADER, 11'd0);
      send_item(header_item(11'd2, 8'd0, 9'd256, 4'hF));
      item = random_item(mff_pkg::FUNC_DATA, 11'd0);
      {item.sample_0, item.sample_1, item.sample_2, item.sample_3} = '1;
      send_item(item);
      {item.sample_0, item.sample_1, item.sample_2, item.sample_3} = '0;
      send_item(item);
      // top lanes map past the last source channel
      send_item(header_item(11'd3, 8'd254, 9'd256, 4'hF));
      send_op(mff_pkg::FUNC_DATA, 11'd0);
      // abandon the partial block above
      send_item(header_item(11'd2, 8'd255, 9'd256, 4'b0101));
      send_op(mff_pkg::FUNC_DATA, 11'd0);
      send_op(mff_pkg::FUNC_DATA, 11'd0);
      send_item(header_item(11'd1, 8'd0, 9'd0, 4'hF));
      send_op(mff_pkg::FUNC_DATA, 11'd0);
      send_op(mff_pkg::FUNC_POP, 11'd0);
      send_op(mff_pkg::FUNC_POP, 11'd2047);
      send_op(mff_pkg::FUNC_POP, 11'd1);
      send_item(header_item(11'd1024, 8'd0, 9'd256, 4'hF));
      send_item(header_item(11'd1, 8'd0, 9'd3, 4'b1110));
      send_op(mff_pkg::FUNC_DATA, 11'd0);
      send_op(mff_pkg::FUNC_POP, 11'd1);
   endtask

   task automatic test_config_limits();
      // zero clamps to one frame and one lane
      write_csr(mff_pkg::CSR_CAPACITY, 11'd0);
      write_csr(mff_pkg::CSR_CHANNELS, 11'd0);
      send_item(header_item(11'd1, 8'd0, 9'd256, 4'hF));
      send_op(mff_pkg::FUNC_DATA, 11'd0);
      send_item(header_item(11'd1, 8'd0, 9'd256, 4'hF));
      send_op(mff_pkg::FUNC_POP, 11'd2);
      // oversize values clamp to the full ring and all lanes
      write_csr(mff_pkg::CSR_CAPACITY, 11'd2047);
      write_csr(mff_pkg::CSR_CHANNELS, 11'd7);
      send_item(header_item(11'd2, 8'd0, 9'd256, 4'hF));
      send_op(mff_pkg::FUNC_DATA, 11'd0);
      send_op(mff_pkg::FUNC_DATA, 11'd0);
      send_op(mff_pkg::FUNC_POP, 11'd2);
      // two-frame ring: wrap the pointers
      write_csr(mff_pkg::CSR_CAPACITY, 11'd2);
      for (int i = 0; i < 3; i++) begin
         send_item(header_item(11'd1, 8'd0, 9'd256, 4'hF));
         send_op(mff_pkg::FUNC_DATA, 11'd0);
      end
      send_op(mff_pkg::FUNC_POP, 11'd3);
      send_item(header_item(11'd2, 8'd1, 9'd4, 4'hF));
      send_op(mff_pkg::FUNC_DATA, 11'd0);
      send_op(mff_pkg::FUNC_DATA, 11'd0);
      send_op(mff_pkg::FUNC_POP, 11'd3);
   endtask

   task automatic send_random_sequence();
      int pick;
      int frames;
      int limit;
      pick = $urandom_range(0, 9);
      limit = (ring_capacity() < 8) ? ring_capacity() : 8;
      if (pick < 6) begin
         frames = $urandom_range(1, limit);
         send_op(mff_pkg::FUNC_HEADER, 11'(frames));
         repeat (frames) send_op(mff_pkg::FUNC_DATA, 11'd0);
         if ($urandom_range(0, 1))
            send_op(mff_pkg::FUNC_POP, 11'($urandom_range(1, 12)));
      end else begin
         case (pick)
            6: send_op(mff_pkg::FUNC_POP, 11'($urandom_range(0, 2047)));
            7: begin
               frames = $urandom_range(2, 8);
               send_op(mff_pkg::FUNC_HEADER, 11'(frames));
               repeat ($urandom_range(0, frames - 1)) send_op(mff_pkg::FUNC_DATA, 11'd0);
            end
            8: send_op(mff_pkg::FUNC_HEADER, 11'($urandom_range(0, 2047)));
            default: send_op($urandom_range(0, 1) ? mff_pkg::FUNC_DATA : FUNC_UNUSED, 11'd0);
         endcase
      end
   endtask

   task automatic test_random_traffic();
      logic [10:0] caps [6] = '{11'd1024, 11'd3, 11'd1, 11'd7, 11'd16, 11'd1500};
      logic [10:0] lanes [6] = '{11'd4, 11'd1, 11'd2, 11'd3, 11'd4, 11'd5};
      int start;
      for (int phase = 0; phase < 6; phase++) begin
         write_csr(mff_pkg::CSR_CAPACITY, caps[phase]);
         write_csr(mff_pkg::CSR_CHANNELS, lanes[phase]);
         start = items_sent;
         while (items_sent - start < PHASE_ITEMS) send_random_sequence();
      end
   endtask

   // Hold the result side off so that the block backs up into req_full.
   task automatic test_backpressure();
      write_csr(mff_pkg::CSR_CAPACITY, 11'd1024);
      write_csr(mff_pkg::CSR_CHANNELS, 11'd4);
      hold_request = 1'b1;
      while (!hold_active) @(posedge clock);
      sender_no_gap = 1'b1;
      send_op(mff_pkg::FUNC_HEADER, 11'd64);
      repeat (64) send_op(mff_pkg::FUNC_DATA, 11'd0);
      send_op(mff_pkg::FUNC_POP, 11'd2047);
      repeat (6) send_op(mff_pkg::FUNC_HEADER, 11'd0);
      sender_no_gap = 1'b0;
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_ops();
      test_config_limits();
      test_backpressure();
      test_random_traffic();
      wait_idle();
      if (mismatch_count == 0)
         $display("PASS multichannel_frame_fifo");
      else
         $display("FAIL multichannel_frame_fifo");
      $finish;
   end

endmodule
